>>> hw/rtl/cdl_pkg.sv
// ----------------------------------------------------------------------------
// cdl_pkg
// Shared types, codes and the command length table of the command deframer.
// ----------------------------------------------------------------------------
package cdl_pkg;

	localparam logic [4:0]  OP_INIT         = 5'd0;
	localparam logic [4:0]  OP_LOCK_A       = 5'd1;
	localparam logic [4:0]  OP_LOCK_B       = 5'd2;
	localparam logic [4:0]  OP_STRING       = 5'd17;
	localparam logic [4:0]  OP_LAST         = 5'd17;
	localparam logic [31:0] KEY_RESET       = 32'h8FE9_9CD4;
	localparam logic [7:0]  MASK_PRIMARY    = 8'h01;
	localparam logic [7:0]  MASK_SECONDARY  = 8'h02;
	localparam logic [3:0]  POS_SAT         = 4'd8;
	localparam logic [3:0]  KEY_LAST_POS    = 4'd4;

	typedef enum logic [0:0] {
		REG_UNLOCK_KEY = 1'b0,
		REG_NODE_SEC   = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		EV_IGNORED = 4'd0,
		EV_START   = 4'd1,
		EV_PAYLOAD = 4'd2,
		EV_DONE    = 4'd3,
		EV_SCHAR   = 4'd4,
		EV_SEND    = 4'd5,
		EV_UNLOCK  = 4'd6,
		EV_REFUSED = 4'd7,
		EV_LOCKERR = 4'd8,
		EV_RESTART = 4'd9
	} event_t;

	typedef struct packed {
		logic        unlocked;
		logic [4:0]  cur_op;
		logic [3:0]  bytes_left;
		logic [3:0]  position;
		logic [31:0] key_shift;
		logic        string_mode;
	} frm_state_t;

	typedef struct packed {
		event_t      ev;
		logic [4:0]  opcode;
		logic [3:0]  byte_offset;
		logic [7:0]  data;
		logic        unlocked;
	} frm_result_t;

	function automatic logic [3:0] cmd_len(input logic [4:0] op);
		logic [3:0] len;
		case (op)
			5'd0:    len = 4'd6;
			5'd1:    len = 4'd2;
			5'd2:    len = 4'd3;
			5'd3:    len = 4'd3;
			5'd4:    len = 4'd9;
			5'd5:    len = 4'd2;
			5'd6:    len = 4'd5;
			5'd7:    len = 4'd1;
			5'd8:    len = 4'd3;
			5'd9:    len = 4'd2;
			5'd10:   len = 4'd1;
			5'd11:   len = 4'd1;
			5'd12:   len = 4'd4;
			5'd13:   len = 4'd2;
			5'd14:   len = 4'd2;
			5'd15:   len = 4'd3;
			5'd16:   len = 4'd2;
			5'd17:   len = 4'd1;
			default: len = 4'd1;
		endcase
		return len;
	endfunction

endpackage

>>> hw/rtl/cdl_step.sv
// ----------------------------------------------------------------------------
// cdl_step
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
module cdl_step import cdl_pkg::*; (
	input  frm_state_t  st,
	input  logic [7:0]  rx,
	input  logic [31:0] unlock_key,
	input  logic        node_sec,
	output frm_state_t  nxt,
	output frm_result_t res
);

	logic [4:0]  limit;
	logic [7:0]  mask;
	logic [3:0]  pos_sat;
	logic [3:0]  pos_inc;
	logic [3:0]  bl_dec;
	logic [3:0]  len;
	logic [31:0] key_upd;

	assign limit   = st.unlocked ? OP_LAST : OP_INIT;
	assign mask    = node_sec ? MASK_SECONDARY : MASK_PRIMARY;
	assign pos_sat = (st.position < POS_SAT) ? st.position + 4'd1 : st.position;
	assign pos_inc = st.position + 4'd1;
	assign bl_dec  = st.bytes_left - 4'd1;
	assign len     = cmd_len(rx[4:0]);
	assign key_upd = (st.cur_op == OP_INIT && pos_inc <= KEY_LAST_POS) ?
	                 {rx, st.key_shift[31:8]} : st.key_shift;

	always_comb begin
		nxt             = st;
		res.ev          = EV_IGNORED;
		res.opcode      = st.cur_op;
		res.byte_offset = st.position;
		res.data        = rx;
		if (st.string_mode) begin
			nxt.position    = pos_sat;
			res.opcode      = OP_STRING;
			res.byte_offset = pos_sat;
			if (rx == 8'd0) begin
				nxt.string_mode = 1'b0;
				nxt.bytes_left  = 4'd0;
				res.ev          = EV_SEND;
			end else begin
				res.ev = EV_SCHAR;
			end
		end else if (st.bytes_left == 4'd0) begin
			res.opcode      = rx[4:0];
			res.byte_offset = 4'd0;
			if (rx > {3'b000, limit}) begin
				nxt.unlocked = 1'b0;
				res.ev       = EV_LOCKERR;
			end else begin
				nxt.cur_op    = rx[4:0];
				nxt.position  = 4'd0;
				nxt.key_shift = 32'd0;
				if (len == 4'd1) begin
					if (rx[4:0] == OP_STRING) begin
						nxt.string_mode = 1'b1;
						res.ev          = EV_START;
					end else begin
						res.ev = EV_DONE;
					end
				end else begin
					nxt.bytes_left = len - 4'd1;
					res.ev         = EV_START;
				end
			end
		end else if (rx == 8'd0 && !st.unlocked) begin
			nxt.cur_op      = OP_INIT;
			nxt.bytes_left  = cmd_len(OP_INIT) - 4'd1;
			nxt.position    = 4'd0;
			nxt.key_shift   = 32'd0;
			res.ev          = EV_RESTART;
			res.opcode      = OP_INIT;
			res.byte_offset = 4'd0;
		end else begin
			nxt.position    = pos_inc;
			nxt.bytes_left  = bl_dec;
			nxt.key_shift   = key_upd;
			res.byte_offset = pos_inc;
			if (bl_dec != 4'd0) begin
				res.ev = EV_PAYLOAD;
			end else if (st.cur_op == OP_INIT) begin
				if (key_upd == unlock_key && (rx & mask) != 8'd0) begin
					nxt.unlocked = 1'b1;
					res.ev       = EV_UNLOCK;
				end else begin
					res.ev = EV_REFUSED;
				end
			end else if (st.cur_op == OP_LOCK_A || st.cur_op == OP_LOCK_B) begin
				nxt.unlocked = 1'b0;
				res.ev       = EV_LOCKERR;
			end else begin
				res.ev = EV_DONE;
			end
		end
		res.unlocked = nxt.unlocked;
	end

endmodule

>>> hw/rtl/command_deframer_with_lock_top.sv
// path: a request is accepted into the input register, and its result is
// loaded into the output register once that register is free or being read
// throughput: one byte per cycle unless the output stalls, the input and
// output registers part the two sides so a byte is taken while a result waits
// reset: arst_n clears control state, locks the block and loads key defaults
// ----------------------------------------------------------------------------
// command_deframer_with_lock_top
// Byte-wise command deframer with init key lock.
// ----------------------------------------------------------------------------
module command_deframer_with_lock_top import cdl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_res,
	output logic [4:0]  opcode,
	output logic [3:0]  byte_offset,
	output logic [7:0]  data,
	output logic        unlocked,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  rx_s1;
	logic        out_valid_q;
	frm_result_t res_q;
	frm_state_t  state_q;
	frm_state_t  state_nxt;
	frm_result_t step_res;
	logic [31:0] unlock_key_q;
	logic        node_sec_q;
	logic        advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	cdl_step u_step (
		.st         (state_q),
		.rx         (rx_s1),
		.unlock_key (unlock_key_q),
		.node_sec   (node_sec_q),
		.nxt        (state_nxt),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlock_key_q <= KEY_RESET;
			node_sec_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_UNLOCK_KEY: unlock_key_q <= cfg_data;
				REG_NODE_SEC:   node_sec_q   <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = res_q.ev;
	assign opcode      = res_q.opcode;
	assign byte_offset = res_q.byte_offset;
	assign data        = res_q.data;
	assign unlocked    = res_q.unlocked;

	a_unlock_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res.ev == EV_UNLOCK |=> state_q.unlocked)
		else $error("unlock event without unlocked state");

	a_lockerr_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res.ev == EV_LOCKERR |=> !state_q.unlocked)
		else $error("lock error event left block unlocked");

	a_string_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.string_mode |-> state_q.cur_op == OP_STRING)
		else $error("string mode with wrong opcode");

	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a full pipeline");

endmodule
